@@ rtl/core/mrs_pkg.sv @@
package mrs_pkg;

	// Queue geometry and message id width.
	localparam int PROFILE_DEPTH = 16;
	localparam int COMMAND_DEPTH = 16;
	localparam int ID_BITS       = 8;

	localparam int PROF_AW = $clog2(PROFILE_DEPTH);
	localparam int PROF_CW = $clog2(PROFILE_DEPTH + 1);
	localparam int CMDQ_AW = $clog2(COMMAND_DEPTH);
	localparam int CMDQ_CW = $clog2(COMMAND_DEPTH + 1);

	// Working width for moving ids between the 8-bit ports and the queues.
	localparam int ID_WIDE = (ID_BITS > 8) ? ID_BITS : 8;

	localparam int MAX_EVENTS = 4;

	typedef enum logic [2:0] {
		CMD_TICK          = 3'd0,
		CMD_REPLY         = 3'd1,
		CMD_ADD_PROFILE   = 3'd2,
		CMD_ADD_COMMAND   = 3'd3,
		CMD_START         = 3'd4,
		CMD_STOP          = 3'd5,
		CMD_BEGIN_PROFILE = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		EV_SEND_PROFILE = 3'd0,
		EV_SEND_COMMAND = 3'd1,
		EV_SEND_QUERY   = 3'd2,
		EV_LINK_OK      = 3'd3,
		EV_LINK_LOST    = 3'd4,
		EV_PROFILE_DONE = 3'd5,
		EV_QUEUE_FULL   = 3'd6
	} ev_kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_PROFILE   = 2'd1,
		MODE_ACTIVE    = 2'd2,
		MODE_CANCELLED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_QUERY_ID      = 2'd0,
		CFG_PROFILE_LIMIT = 2'd1,
		CFG_COMMAND_LIMIT = 2'd2,
		CFG_QUERY_LIMIT   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_EMIT
	} fsm_t;

	// Awaiting-reply flag bit positions.
	localparam int WAIT_PROFILE = 0;
	localparam int WAIT_QUERY   = 1;
	localparam int WAIT_COMMAND = 2;

	// Reply code classes.
	localparam logic [7:0] RC_PROFILE_LO = 8'h64;
	localparam logic [7:0] RC_PROFILE_HI = 8'h6E;
	localparam logic [7:0] RC_QUERY      = 8'h32;
	localparam logic [7:0] RC_CMD_A      = 8'h0A;
	localparam logic [7:0] RC_CMD_C      = 8'h0C;
	localparam logic [7:0] RC_CMD_D      = 8'h0D;
	localparam logic [7:0] RC_CMD_E      = 8'h0E;
	localparam logic [7:0] RC_CMD_ACK    = 8'h33;
	localparam logic [7:0] RC_BULK_LO    = 8'h96;
	localparam logic [7:0] RC_BULK_HI    = 8'hB4;

	localparam logic [7:0] RST_QUERY_ID      = 8'd0;
	localparam logic [5:0] RST_PROFILE_LIMIT = 6'd50;
	localparam logic [5:0] RST_COMMAND_LIMIT = 6'd20;
	localparam logic [5:0] RST_QUERY_LIMIT   = 6'd10;

	function automatic logic [ID_BITS-1:0] to_id(input logic [7:0] v);
		logic [ID_WIDE-1:0] w;
		w = ID_WIDE'(v);
		return w[ID_BITS-1:0];
	endfunction

	function automatic logic [7:0] from_id(input logic [ID_BITS-1:0] v);
		logic [ID_WIDE-1:0] w;
		w = ID_WIDE'(v);
		return w[7:0];
	endfunction

endpackage

@@ rtl/core/mrs_ram.sv @@
module mrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/message_retry_scheduler_unit.sv @@
// Flow: an accepted request passes through the read state, where both queue heads are
// read, and the execute state; its results are then offered in the emit state.
// Results go out one per cycle while out_ready is high, and no new request is accepted
// until the last result of the previous one has been taken.
// A request that causes no result returns to idle from execute; results per request are 0 to 4.
// Reset clears mode, phase, flags, loss counters, queue pointers and the configuration
// registers to their defaults; queue RAM contents are not reset and are never read stale.
module message_retry_scheduler_unit
	import mrs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] cmd,
	input  logic [7:0] reply_code,
	input  logic [7:0] message_id,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_kind,
	output logic [7:0] sent_id,
	output logic       last,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	fsm_t state_q, state_d;

	logic [7:0] query_id_q;
	logic [5:0] prof_limit_q, cmd_limit_q, query_limit_q;

	mode_t      mode_q, mode_d;
	logic       phase_q, phase_d;
	logic [2:0] flags_q, flags_d;
	logic [5:0] plos_q, plos_d, clos_q, clos_d, qlos_q, qlos_d;

	logic [PROF_AW-1:0] phead_q, phead_d;
	logic [PROF_CW-1:0] pcnt_q, pcnt_d;
	logic [CMDQ_AW-1:0] chead_q, chead_d;
	logic [CMDQ_CW-1:0] ccnt_q, ccnt_d;

	logic [2:0] cmd_q;
	logic [7:0] code_q, id_q;

	ev_kind_t   ev_kind_q [MAX_EVENTS];
	logic [7:0] ev_id_q   [MAX_EVENTS];
	ev_kind_t   ev_kind_d [MAX_EVENTS];
	logic [7:0] ev_id_d   [MAX_EVENTS];
	logic [2:0] ev_cnt_q, ev_n;
	logic [1:0] ev_idx_q;

	logic exec_en, emit_hs, in_hs, last_ev;

	logic [ID_BITS-1:0] prof_rdata, cmd_rdata;
	logic               prof_we, cmd_we;
	logic [PROF_AW-1:0] prof_waddr;
	logic [CMDQ_AW-1:0] cmd_waddr;
	logic [PROF_AW:0]   prof_tail;
	logic [CMDQ_AW:0]   cmd_tail;
	logic [5:0]         plos_inc, clos_inc, qlos_inc;
	logic               rc_profile, rc_query, rc_cmd, rc_bulk;

	// The read address always follows the head, so the head entry is ready in ST_EXEC.
	mrs_ram #(.WIDTH(ID_BITS), .DEPTH(PROFILE_DEPTH)) u_prof_ram (
		.clk   (clk),
		.we    (prof_we),
		.waddr (prof_waddr),
		.wdata (to_id(id_q)),
		.raddr (phead_q),
		.rdata (prof_rdata)
	);

	mrs_ram #(.WIDTH(ID_BITS), .DEPTH(COMMAND_DEPTH)) u_cmd_ram (
		.clk   (clk),
		.we    (cmd_we),
		.waddr (cmd_waddr),
		.wdata (to_id(id_q)),
		.raddr (chead_q),
		.rdata (cmd_rdata)
	);

	assign in_hs   = in_valid && in_ready;
	assign emit_hs = out_valid && out_ready;
	assign last_ev = ({1'b0, ev_idx_q} == (ev_cnt_q - 3'd1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: state_d = (ev_n == 3'd0) ? ST_IDLE : ST_EMIT;
			ST_EMIT: if (out_ready && last_ev) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		exec_en   = (state_q == ST_EXEC);
	end

	assign event_kind = ev_kind_q[ev_idx_q];
	assign sent_id    = ev_id_q[ev_idx_q];
	assign last       = last_ev;

	assign rc_profile = (code_q >= RC_PROFILE_LO) && (code_q <= RC_PROFILE_HI);
	assign rc_query   = (code_q == RC_QUERY);
	assign rc_cmd     = (code_q == RC_CMD_A) || (code_q == RC_CMD_C) || (code_q == RC_CMD_D)
		|| (code_q == RC_CMD_E) || (code_q == RC_CMD_ACK);
	assign rc_bulk    = (code_q >= RC_BULK_LO) && (code_q <= RC_BULK_HI);

	assign plos_inc = plos_q + 6'd1;
	assign clos_inc = clos_q + 6'd1;
	assign qlos_inc = qlos_q + 6'd1;

	// Tail slot is head plus count, folded back once into the queue depth.
	assign prof_tail = (PROF_AW+1)'(phead_q) + (PROF_AW+1)'(pcnt_q);
	assign cmd_tail  = (CMDQ_AW+1)'(chead_q) + (CMDQ_AW+1)'(ccnt_q);
	assign prof_waddr = (prof_tail >= (PROF_AW+1)'(PROFILE_DEPTH))
		? PROF_AW'(prof_tail - (PROF_AW+1)'(PROFILE_DEPTH)) : PROF_AW'(prof_tail);
	assign cmd_waddr  = (cmd_tail >= (CMDQ_AW+1)'(COMMAND_DEPTH))
		? CMDQ_AW'(cmd_tail - (CMDQ_AW+1)'(COMMAND_DEPTH)) : CMDQ_AW'(cmd_tail);

	always_comb begin
		mode_d  = mode_q;
		phase_d = phase_q;
		flags_d = flags_q;
		plos_d  = plos_q;
		clos_d  = clos_q;
		qlos_d  = qlos_q;
		phead_d = phead_q;
		pcnt_d  = pcnt_q;
		chead_d = chead_q;
		ccnt_d  = ccnt_q;
		prof_we = 1'b0;
		cmd_we  = 1'b0;
		ev_n    = 3'd0;
		for (int i = 0; i < MAX_EVENTS; i++) begin
			ev_kind_d[i] = EV_LINK_OK;
			ev_id_d[i]   = 8'd0;
		end

		unique case (cmd_q)
			CMD_TICK: begin
				if (mode_q == MODE_PROFILE) begin
					if (flags_q[WAIT_PROFILE]) begin
						if (plos_inc >= prof_limit_q) begin
							plos_d = 6'd0;
							ev_kind_d[ev_n[1:0]] = EV_LINK_LOST;
							ev_n = ev_n + 3'd1;
						end else begin
							plos_d = plos_inc;
						end
					end
					if (pcnt_q != '0) begin
						ev_kind_d[ev_n[1:0]] = EV_SEND_PROFILE;
						ev_id_d[ev_n[1:0]]   = from_id(prof_rdata);
						ev_n = ev_n + 3'd1;
						flags_d[WAIT_PROFILE] = 1'b1;
					end
				end else if (mode_q == MODE_ACTIVE && phase_q) begin
					if (flags_q[WAIT_QUERY]) begin
						if (qlos_inc >= query_limit_q) begin
							qlos_d = 6'd0;
							ev_kind_d[ev_n[1:0]] = EV_LINK_LOST;
							ev_n = ev_n + 3'd1;
						end else begin
							qlos_d = qlos_inc;
						end
					end
					ev_kind_d[ev_n[1:0]] = EV_SEND_QUERY;
					ev_id_d[ev_n[1:0]]   = from_id(to_id(query_id_q));
					ev_n = ev_n + 3'd1;
					flags_d[WAIT_QUERY] = 1'b1;
				end
				// Commands go out on tic ticks only, and a loss counts only with work queued.
				if (!phase_q && ccnt_q != '0) begin
					if (flags_q[WAIT_COMMAND]) begin
						if (clos_inc >= cmd_limit_q) begin
							clos_d = 6'd0;
							ev_kind_d[ev_n[1:0]] = EV_LINK_LOST;
							ev_n = ev_n + 3'd1;
						end else begin
							clos_d = clos_inc;
						end
					end
					ev_kind_d[ev_n[1:0]] = EV_SEND_COMMAND;
					ev_id_d[ev_n[1:0]]   = from_id(cmd_rdata);
					ev_n = ev_n + 3'd1;
					flags_d[WAIT_COMMAND] = 1'b1;
				end
				phase_d = ~phase_q;
			end
			CMD_REPLY: begin
				ev_kind_d[ev_n[1:0]] = EV_LINK_OK;
				ev_n = ev_n + 3'd1;
				if (rc_profile) begin
					plos_d = 6'd0;
					if (mode_q == MODE_PROFILE) begin
						if (pcnt_q != '0) begin
							phead_d = (phead_q == PROF_AW'(PROFILE_DEPTH - 1))
								? '0 : phead_q + PROF_AW'(1);
							pcnt_d  = pcnt_q - PROF_CW'(1);
							flags_d[WAIT_PROFILE] = 1'b0;
						end
						if (pcnt_d == '0) begin
							mode_d = MODE_IDLE;
							ev_kind_d[ev_n[1:0]] = EV_PROFILE_DONE;
							ev_n = ev_n + 3'd1;
						end
					end
				end
				if (rc_query) begin
					qlos_d = 6'd0;
					flags_d[WAIT_QUERY] = 1'b0;
				end
				if (rc_cmd) begin
					clos_d = 6'd0;
				end
				if ((rc_cmd || rc_bulk) && ccnt_q != '0) begin
					chead_d = (chead_q == CMDQ_AW'(COMMAND_DEPTH - 1))
						? '0 : chead_q + CMDQ_AW'(1);
					ccnt_d  = ccnt_q - CMDQ_CW'(1);
					flags_d[WAIT_COMMAND] = 1'b0;
				end
			end
			CMD_ADD_PROFILE: begin
				if (pcnt_q >= PROF_CW'(PROFILE_DEPTH)) begin
					ev_kind_d[ev_n[1:0]] = EV_QUEUE_FULL;
					ev_n = ev_n + 3'd1;
				end else begin
					prof_we = exec_en;
					pcnt_d  = pcnt_q + PROF_CW'(1);
				end
			end
			CMD_ADD_COMMAND: begin
				if (ccnt_q >= CMDQ_CW'(COMMAND_DEPTH)) begin
					ev_kind_d[ev_n[1:0]] = EV_QUEUE_FULL;
					ev_n = ev_n + 3'd1;
				end else begin
					cmd_we = exec_en;
					ccnt_d = ccnt_q + CMDQ_CW'(1);
				end
			end
			CMD_START:         mode_d = MODE_ACTIVE;
			CMD_STOP:          mode_d = MODE_CANCELLED;
			CMD_BEGIN_PROFILE: mode_d = MODE_PROFILE;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			query_id_q    <= RST_QUERY_ID;
			prof_limit_q  <= RST_PROFILE_LIMIT;
			cmd_limit_q   <= RST_COMMAND_LIMIT;
			query_limit_q <= RST_QUERY_LIMIT;
			mode_q        <= MODE_IDLE;
			phase_q       <= 1'b0;
			flags_q       <= 3'd0;
			plos_q        <= 6'd0;
			clos_q        <= 6'd0;
			qlos_q        <= 6'd0;
			phead_q       <= '0;
			pcnt_q        <= '0;
			chead_q       <= '0;
			ccnt_q        <= '0;
			ev_cnt_q      <= 3'd0;
			ev_idx_q      <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_QUERY_ID:      query_id_q    <= cfg_data;
					CFG_PROFILE_LIMIT: prof_limit_q  <= cfg_data[5:0];
					CFG_COMMAND_LIMIT: cmd_limit_q   <= cfg_data[5:0];
					CFG_QUERY_LIMIT:   query_limit_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (exec_en) begin
				mode_q   <= mode_d;
				phase_q  <= phase_d;
				flags_q  <= flags_d;
				plos_q   <= plos_d;
				clos_q   <= clos_d;
				qlos_q   <= qlos_d;
				phead_q  <= phead_d;
				pcnt_q   <= pcnt_d;
				chead_q  <= chead_d;
				ccnt_q   <= ccnt_d;
				ev_cnt_q <= ev_n;
				ev_idx_q <= 2'd0;
			end else if (emit_hs && !last_ev) begin
				ev_idx_q <= ev_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_hs) begin
			cmd_q  <= cmd;
			code_q <= reply_code;
			id_q   <= message_id;
		end
		if (exec_en) begin
			for (int i = 0; i < MAX_EVENTS; i++) begin
				ev_kind_q[i] <= ev_kind_d[i];
				ev_id_q[i]   <= ev_id_d[i];
			end
		end
	end

`ifndef SYNTHESIS
	a_prof_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PROF_CW'(PROFILE_DEPTH))
		else $error("profile queue count exceeds depth");

	a_cmd_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ccnt_q <= CMDQ_CW'(COMMAND_DEPTH))
		else $error("command queue count exceeds depth");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ev_cnt_q != 3'd0) && (ev_cnt_q <= 3'(MAX_EVENTS)))
		else $error("result offered with an empty event buffer");

	a_accept_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_hs |=> !out_valid && !in_ready)
		else $error("request accepted while results still pending");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_hs && last) |=> in_ready && !out_valid)
		else $error("input not reopened after final result");
`endif

endmodule
